FILE: rtl/mact_pkg.sv
// Package for the MAC address table: item types, op codes, hash helpers.
// No dependencies.
package mact_pkg;
  localparam int KEY_W = 60;
  localparam int PORT_W = 24;
  localparam int ADDR_W = 14;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_DEL_KEY = 3'd2;
  localparam logic [2:0] OP_UPD_ADDR = 3'd3;
  localparam logic [2:0] OP_DEL_ADDR = 3'd4;

  localparam logic [1:0] HM_LOW12 = 2'd0;
  localparam logic [1:0] HM_SPLIT8 = 2'd1;
  localparam logic [1:0] HM_SPLIT4 = 2'd2;
  localparam logic [1:0] HM_HIGH12 = 2'd3;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;

  typedef struct packed {
    logic [2:0] operation;
    logic [47:0] mac_addr;
    logic [11:0] learn_group;
    logic lock_flag;
    logic [23:0] dest_ports;
    logic [13:0] entry_address;
  } req_t;

  typedef struct packed {
    logic hit;
    logic [13:0] result_address;
  } rsp_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [15:0] fold_hash(input logic [47:0] mac, input logic [11:0] grp);
    logic [31:0] c;
    logic [15:0] g;
    c = 32'hffffffff;
    g = {4'd0, grp};
    for (int i = 0; i < 6; i++) begin
      c = crc_byte(c, mac[8*i +: 8]);
    end
    c = crc_byte(c, g[15:8]);
    c = crc_byte(c, g[7:0]);
    c = ~c;
    return {c[7:0] ^ c[15:8], c[23:16] ^ c[31:24]};
  endfunction

  function automatic logic [15:0] pick_index(input logic [15:0] f, input logic [1:0] mode);
    logic [15:0] s;
    s = f >> 4;
    case (mode)
      HM_LOW12: pick_index = f & 16'h0fff;
      HM_SPLIT8: pick_index = (f & 16'h00ff) | (s & 16'hff00);
      HM_SPLIT4: pick_index = (f & 16'h000f) | (s & 16'hfff0);
      default: pick_index = s;
    endcase
  endfunction
endpackage

FILE: rtl/mact_front.sv
// Front end: accepts a request, hashes the key into a set index, queues it.
// Depends on mact_pkg.
module mact_front #(
  parameter int SET_BITS = 11
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  mact_pkg::req_t req,
  input  logic [1:0] hash_mode,
  input  logic q_full,
  output logic q_push,
  output mact_pkg::req_t q_req,
  output logic [SET_BITS-1:0] q_set,
  output logic accept
);
  logic pend;
  mact_pkg::req_t preq;
  logic [15:0] pidx;

  assign accept = start && !pend;
  assign q_push = pend && !q_full;
  assign q_req = preq;
  assign q_set = pidx[SET_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      if (accept) begin
        pend <= 1'b1;
      end else if (q_push) begin
        pend <= 1'b0;
      end
    end
    if (accept) begin
      preq <= req;
      pidx <= mact_pkg::pick_index(mact_pkg::fold_hash(req.mac_addr, req.learn_group),
        hash_mode);
    end
  end
endmodule

FILE: rtl/mact_queue.sv
// Two-entry queue of hashed requests between front and back ends.
// Depends on mact_pkg.
module mact_queue #(
  parameter int SET_BITS = 11
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  mact_pkg::req_t push_req,
  input  logic [SET_BITS-1:0] push_set,
  output logic full,
  output logic empty,
  input  logic pop,
  output mact_pkg::req_t pop_req,
  output logic [SET_BITS-1:0] pop_set
);
  mact_pkg::req_t qreq [2];
  logic [SET_BITS-1:0] qset [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full = cnt[1];
  assign empty = (cnt == 2'd0);
  assign pop_req = qreq[rp];
  assign pop_set = qset[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      qreq[wp] <= push_req;
      qset[wp] <= push_set;
    end
  end
endmodule

FILE: rtl/mact_back.sv
// Back end: reads one set across all banks, decides, writes back, responds.
// Depends on mact_pkg. Holds the table memories and the sweep that clears them.
module mact_back #(
  parameter int BANKS = 8,
  parameter int SET_BITS = 11
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  mact_pkg::req_t q_req,
  input  logic [SET_BITS-1:0] q_set,
  output logic q_pop,
  output logic idle,
  output logic done,
  output mact_pkg::rsp_t rsp
);
  localparam int SETS = 1 << SET_BITS;
  localparam int BW = 3;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_DECIDE} state_t;
  state_t state;

  logic [mact_pkg::KEY_W-1:0] key_mem [BANKS][SETS];
  logic [mact_pkg::PORT_W-1:0] port_mem [BANKS][SETS];
  logic val_mem [BANKS][SETS];
  logic lock_mem [BANKS][SETS];

  logic [mact_pkg::KEY_W-1:0] rd_key [BANKS];
  logic rd_val [BANKS];
  logic rd_lock [BANKS];

  mact_pkg::req_t cur;
  logic [SET_BITS-1:0] cur_set;
  logic [SET_BITS-1:0] clr;

  logic [mact_pkg::KEY_W-1:0] key;
  logic addr_op, in_range;
  logic [BW-1:0] abank;
  logic [SET_BITS-1:0] aset;
  logic [SET_BITS-1:0] rset;

  logic f_ok, e_ok, d_ok, k_ok;
  logic [BW-1:0] f_b, e_b, d_b, k_b;
  logic whit, wr, wr_full, wval;
  logic [BW-1:0] wbank;

  assign key = {cur.mac_addr, cur.learn_group};
  assign addr_op = (cur.operation == mact_pkg::OP_UPD_ADDR) ||
                   (cur.operation == mact_pkg::OP_DEL_ADDR);
  assign abank = BW'(cur.entry_address >> SET_BITS);
  assign aset = cur.entry_address[SET_BITS-1:0];
  assign in_range = (cur.entry_address >> SET_BITS) < BANKS;
  assign rset = addr_op ? aset : cur_set;
  assign q_pop = (state == S_IDLE) && !q_empty;
  assign idle = (state == S_IDLE) && q_empty;

  always_comb begin
    f_ok = 1'b0; e_ok = 1'b0; d_ok = 1'b0; k_ok = 1'b0;
    f_b = '0; e_b = '0; d_b = '0; k_b = '0;
    for (int b = 0; b < BANKS; b++) begin
      if (rd_key[b] == key && rd_val[b]) begin f_ok = 1'b1; f_b = BW'(b); end
      if (rd_key[b] == key) begin k_ok = 1'b1; k_b = BW'(b); end
    end
    for (int b = BANKS - 1; b >= 0; b--) begin
      if (!rd_val[b]) begin e_ok = 1'b1; e_b = BW'(b); end
      if (!rd_lock[b]) begin d_ok = 1'b1; d_b = BW'(b); end
    end
    whit = 1'b0; wr = 1'b0; wr_full = 1'b0; wval = 1'b0; wbank = '0;
    case (cur.operation)
      mact_pkg::OP_LOOKUP: begin
        whit = f_ok; wbank = f_b;
      end
      mact_pkg::OP_ADD: begin
        wbank = f_ok ? f_b : (e_ok ? e_b : d_b);
        whit = f_ok || e_ok || d_ok;
        wr = whit; wr_full = 1'b1; wval = 1'b1;
      end
      mact_pkg::OP_DEL_KEY: begin
        whit = k_ok; wbank = k_b; wr = k_ok;
      end
      mact_pkg::OP_UPD_ADDR, mact_pkg::OP_DEL_ADDR: begin
        wbank = abank;
        whit = in_range && rd_key[abank] == key;
        wr = whit;
        wval = (cur.operation == mact_pkg::OP_UPD_ADDR);
      end
      default: begin
        whit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < BANKS; b++) begin
      if (state == S_READ) begin
        rd_key[b] <= key_mem[b][rset];
        rd_val[b] <= val_mem[b][rset];
        rd_lock[b] <= lock_mem[b][rset];
      end
      if (state == S_CLEAR) begin
        val_mem[b][clr] <= 1'b0;
        key_mem[b][clr] <= '0;
        lock_mem[b][clr] <= 1'b0;
        port_mem[b][clr] <= '0;
      end else if (state == S_DECIDE && wr && wbank == BW'(b)) begin
        val_mem[b][rset] <= wval;
        if (wr_full) key_mem[b][rset] <= key;
        if (wval) begin
          port_mem[b][rset] <= cur.dest_ports;
          lock_mem[b][rset] <= cur.lock_flag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == SET_BITS'(SETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_req;
            cur_set <= q_set;
            state <= S_READ;
          end
        end
        S_READ: state <= S_DECIDE;
        S_DECIDE: begin
          done <= 1'b1;
          rsp.hit <= whit;
          rsp.result_address <= whit ?
            mact_pkg::ADDR_W'({wbank, rset} & ((1 << (BW + SET_BITS)) - 1)) : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/mac_address_table_8way_core.sv
// MAC address table top: config register, front hash stage, queue, back end.
// Depends on mact_pkg, mact_front, mact_queue, mact_back.
// Path: the front registers the request and its set index, the queue holds it,
// and the back end handles one item at a time: pop, read, decide/write.
// Reset: a sweep clears all 2^SET_BITS sets; up to three requests are taken
// meanwhile and wait for it. The result strobe lasts one cycle; no receiver stall.
module mac_address_table_8way_core #(
  parameter int BANKS = 8,
  parameter int SET_BITS = 11
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  mact_pkg::req_t req,
  output logic done,
  output mact_pkg::rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_data
);
  logic [1:0] hash_mode;
  logic q_push, q_full, q_empty, q_pop, accept, back_idle;
  mact_pkg::req_t f_req, b_req;
  logic [SET_BITS-1:0] f_set, b_set;
  logic fpend;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode <= mact_pkg::HM_HIGH12;
      fpend <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) hash_mode <= cfg_data;
      if (accept) fpend <= 1'b1;
      else if (q_push) fpend <= 1'b0;
    end
  end

  assign busy = fpend;

  mact_front #(.SET_BITS(SET_BITS)) u_front (
    .clk, .rst, .start, .req, .hash_mode, .q_full, .q_push,
    .q_req(f_req), .q_set(f_set), .accept
  );

  mact_queue #(.SET_BITS(SET_BITS)) u_queue (
    .clk, .rst, .push(q_push), .push_req(f_req), .push_set(f_set), .full(q_full),
    .empty(q_empty), .pop(q_pop), .pop_req(b_req), .pop_set(b_set)
  );

  mact_back #(.BANKS(BANKS), .SET_BITS(SET_BITS)) u_back (
    .clk, .rst, .q_empty, .q_req(b_req), .q_set(b_set), .q_pop,
    .idle(back_idle), .done, .rsp
  );

  a_no_miss_addr: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.hit |-> rsp.result_address == '0) else $error("addr without hit");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("busy not set");
  a_q_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push) else $error("queue overflow");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    back_idle && !q_push |=> !done) else $error("spurious done");
endmodule

FILE: tb/sv/mact_checker.sv
`timescale 1ns / 100ps
// Checker for the MAC address table: watches the request, config and result
// transfers, keeps its own table model, and compares every result. Uses mact_pkg.
module mact_checker (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  mact_pkg::req_t req,
  input  logic done,
  input  mact_pkg::rsp_t rsp,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [1:0] cfg_data,
  output int errors,
  output int pending,
  output int results_seen
);
  localparam int NBANK = 8;
  localparam int NSET_BITS = 11;
  localparam int DEPTH = NBANK << NSET_BITS;

  logic [59:0] tbl_key [DEPTH];
  logic [23:0] tbl_ports [DEPTH];
  logic tbl_valid [DEPTH];
  logic tbl_lock [DEPTH];
  logic [1:0] mode;
  mact_pkg::rsp_t expected_rsp [$];

  function automatic logic [31:0] crc8_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hedb88320) : (r >> 1);
    return r;
  endfunction

  function automatic logic [10:0] set_of(input logic [47:0] mac, input logic [11:0] grp);
    logic [31:0] c;
    logic [15:0] f, idx;
    c = 32'hffffffff;
    for (int i = 0; i < 6; i++) c = crc8_step(c, mac[8*i +: 8]);
    c = crc8_step(c, {4'd0, grp[11:8]});
    c = crc8_step(c, grp[7:0]);
    c = ~c;
    f = {c[7:0] ^ c[15:8], c[23:16] ^ c[31:24]};
    case (mode)
      mact_pkg::HM_LOW12: idx = {4'd0, f[11:0]};
      mact_pkg::HM_SPLIT8: idx = (f & 16'h00ff) | ((f >> 4) & 16'hff00);
      mact_pkg::HM_SPLIT4: idx = (f & 16'h000f) | ((f >> 4) & 16'hfff0);
      default: idx = f >> 4;
    endcase
    return idx[10:0];
  endfunction

  function automatic mact_pkg::rsp_t apply_request(input mact_pkg::req_t r);
    mact_pkg::rsp_t o;
    logic [59:0] key;
    logic [10:0] s;
    int found, empty, dyn, a;
    o = '0;
    key = {r.mac_addr, r.learn_group};
    if (r.operation <= mact_pkg::OP_DEL_KEY) begin
      s = set_of(r.mac_addr, r.learn_group);
      found = -1; empty = -1; dyn = -1;
      for (int b = NBANK - 1; b >= 0; b--) begin
        a = (b << NSET_BITS) + s;
        if (r.operation == mact_pkg::OP_DEL_KEY) begin
          if (tbl_key[a] == key) begin found = b; break; end
        end else begin
          if (tbl_key[a] == key && tbl_valid[a]) begin found = b; break; end
          if (!tbl_valid[a]) empty = b;
          if (!tbl_lock[a]) dyn = b;
        end
      end
      if (r.operation == mact_pkg::OP_ADD && found < 0) found = (empty >= 0) ? empty : dyn;
      if (found >= 0) begin
        a = (found << NSET_BITS) + s;
        o.hit = 1'b1;
        o.result_address = a[13:0];
        if (r.operation == mact_pkg::OP_ADD) begin
          tbl_key[a] = key;
          tbl_ports[a] = r.dest_ports;
          tbl_lock[a] = r.lock_flag;
          tbl_valid[a] = 1'b1;
        end else if (r.operation == mact_pkg::OP_DEL_KEY) begin
          tbl_valid[a] = 1'b0;
        end
      end
    end else if (r.operation == mact_pkg::OP_UPD_ADDR ||
                 r.operation == mact_pkg::OP_DEL_ADDR) begin
      a = r.entry_address;
      if ((a >> NSET_BITS) < NBANK && tbl_key[a] == key) begin
        if (r.operation == mact_pkg::OP_UPD_ADDR) begin
          tbl_ports[a] = r.dest_ports;
          tbl_lock[a] = r.lock_flag;
          tbl_valid[a] = 1'b1;
        end else begin
          tbl_valid[a] = 1'b0;
        end
        o.hit = 1'b1;
        o.result_address = r.entry_address;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    mact_pkg::rsp_t e;
    if (rst) begin
      errors = 0;
      results_seen = 0;
      mode = mact_pkg::HM_HIGH12;
      expected_rsp.delete();
      for (int a = 0; a < DEPTH; a++) begin
        tbl_key[a] = '0; tbl_ports[a] = '0; tbl_valid[a] = 0; tbl_lock[a] = 0;
      end
    end else begin
      if (done) begin
        results_seen++;
        if (expected_rsp.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_rsp.pop_front();
          if (rsp.hit !== e.hit)
            report_mismatch($sformatf("hit %b, expected %b", rsp.hit, e.hit));
          if (rsp.result_address !== e.result_address)
            report_mismatch($sformatf("address %0d, expected %0d",
                                      rsp.result_address, e.result_address));
        end
      end
      if (cfg_valid && cfg_ready) mode = cfg_data;
      if (start && !busy) expected_rsp.push_back(apply_request(req));
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the MAC address table testbench: clock, reset, request and hash mode
// stimulus, verdict. Depends on mact_pkg, mact_checker, mac_address_table_8way_core.
module tb_top;
  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  logic [1:0] cfg_data;
  logic [1:0] cur_mode;
  mact_pkg::req_t req;
  mact_pkg::rsp_t rsp;
  int errors, pending, results_seen, idle_pct, requests_sent, stuck;
  logic [47:0] known_mac [$];
  logic [11:0] known_grp [$];

  mac_address_table_8way_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  mact_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > 20000) begin
      $display("watchdog expired");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(input mact_pkg::req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic write_mode(input logic [1:0] m);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_data <= m;
    cfg_valid <= 1'b1;
    cur_mode = m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic mact_pkg::req_t random_request();
    mact_pkg::req_t r;
    int k;
    logic [15:0] h;
    r.operation = $urandom_range(99) < 95 ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
    r.lock_flag = $urandom_range(3) == 0;
    r.dest_ports = 24'($urandom);
    r.entry_address = 14'($urandom);
    if (known_mac.size() > 0 && $urandom_range(9) < 8) begin
      k = $urandom_range(known_mac.size() - 1);
      r.mac_addr = known_mac[k];
      r.learn_group = known_grp[k];
    end else begin
      r.mac_addr = 48'({$urandom, $urandom});
      r.learn_group = 12'($urandom);
      if (known_mac.size() < 200) begin
        known_mac.push_back(r.mac_addr);
        known_grp.push_back(r.learn_group);
      end
    end
    // steer address ops at the set the key hashes to, most of the time
    if (r.operation >= mact_pkg::OP_UPD_ADDR && $urandom_range(3) != 0) begin
      h = mact_pkg::pick_index(mact_pkg::fold_hash(r.mac_addr, r.learn_group), cur_mode);
      r.entry_address = {3'($urandom_range(7)), h[10:0]};
    end
    return r;
  endfunction

  initial begin
    mact_pkg::req_t r;
    logic [1:0] modes [4] = '{mact_pkg::HM_LOW12, mact_pkg::HM_SPLIT8,
                              mact_pkg::HM_SPLIT4, mact_pkg::HM_HIGH12};
    int phase_idle [4] = '{0, 69, 0, 17};
    rst = 1; start = 0; cfg_valid = 0; cfg_data = 0; req = '0;
    idle_pct = 0; requests_sent = 0; cur_mode = mact_pkg::HM_HIGH12;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: key zero on stale slots, extremes, every operation
    r = '0; r.operation = mact_pkg::OP_DEL_KEY; send_request(r);
    r = '0; r.operation = mact_pkg::OP_UPD_ADDR; r.entry_address = 14'd5; send_request(r);
    r = '0; r.operation = mact_pkg::OP_DEL_ADDR; r.entry_address = 14'h3fff; send_request(r);
    r = '0; r.operation = mact_pkg::OP_LOOKUP; send_request(r);
    for (int i = 0; i < 10; i++) begin
      r = '0; r.operation = mact_pkg::OP_ADD; r.mac_addr = 48'hffffffffffff;
      r.learn_group = 12'hfff; r.dest_ports = 24'hffffff; r.lock_flag = i < 8;
      if (i > 0) r.learn_group = 12'(4095 - i);
      send_request(r);
    end
    r.operation = mact_pkg::OP_LOOKUP; send_request(r);
    r.operation = mact_pkg::OP_UPD_ADDR; r.entry_address = 14'h3fff; send_request(r);
    r.operation = mact_pkg::OP_DEL_KEY; send_request(r);
    r.operation = mact_pkg::OP_DEL_ADDR; send_request(r);
    for (int op = 5; op < 8; op++) begin
      r.operation = op[2:0]; send_request(r);
    end

    for (int p = 0; p < 4; p++) begin
      write_mode(modes[p]);
      idle_pct = phase_idle[p];
      for (int i = 0; i < 350; i++) send_request(random_request());
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("%0d requests, %0d results checked, all four hash modes, idle 0-69%%",
             requests_sent, results_seen);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
